// File: hw/rtl/cdc_pkg.sv
// Shared types, codes and calendar helper functions for the date counter.
`timescale 1ns / 1ps

package cdc_pkg;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int DIFF_W   = 23;
    localparam int MOD100_W = 7;
    localparam int MOD400_W = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEC  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DIFF = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_YEAR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_DATE   = 3'd5;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

    // day number arithmetic
    localparam int DAYS_PER_YEAR = 365;
    localparam int DN_BIAS       = 306;
    localparam int DIV100_MUL    = 5243;  // floor(y/100) = (y*5243) >> 19 for 14-bit y
    localparam int DIV100_SHIFT  = 19;
    localparam int DN_W          = 24;    // working width, result fits DIFF_W

    localparam logic [MOD100_W-1:0] MOD100_LAST = 7'd99;
    localparam logic [MOD400_W-1:0] MOD400_LAST = 9'd399;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified request as it travels from front to back
    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [STATUS_W-1:0] chk;      // validity of the given date
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [YEAR_W-1:0]   year;
        logic [MOD100_W-1:0] mod100;   // year mod 100
        logic [MOD400_W-1:0] mod400;   // year mod 400
        logic [DIFF_W-1:0]   dnum;     // March-based day number of the given date
    } cdc_item_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } cdc_q_status_t;

    function automatic logic is_leap(input logic [MOD100_W-1:0] mod100,
                                     input logic [MOD400_W-1:0] mod400);
        is_leap = (mod400 == '0) || ((mod100 != '0) && (mod400[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
            days_in = 5'd31;
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            days_in = 5'd30;
        end else if (month == MONTH_FEB) begin
            days_in = leap ? 5'd29 : 5'd28;
        end else begin
            days_in = 5'd0;
        end
    endfunction

    // (153*m' - 457)/5 with m' = m+12 for Jan/Feb
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] month);
        case (month)
            4'd1:    month_offset = 9'd306;
            4'd2:    month_offset = 9'd337;
            4'd3:    month_offset = 9'd0;
            4'd4:    month_offset = 9'd31;
            4'd5:    month_offset = 9'd61;
            4'd6:    month_offset = 9'd92;
            4'd7:    month_offset = 9'd122;
            4'd8:    month_offset = 9'd153;
            4'd9:    month_offset = 9'd184;
            4'd10:   month_offset = 9'd214;
            4'd11:   month_offset = 9'd245;
            4'd12:   month_offset = 9'd275;
            default: month_offset = 9'd0;
        endcase
    endfunction

endpackage

// File: hw/rtl/cdc_front.sv
// Front end: checks the given date and works out its leap data and day number.
`timescale 1ns / 1ps

module cdc_front
    import cdc_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic [REQ_W-1:0]   req_type,
    input  logic [MONTH_W-1:0] in_month,
    input  logic [DAY_W-1:0]   in_day,
    input  logic [YEAR_W-1:0]  in_year,
    output cdc_item_t          item
);

    logic [26:0]         prod100;
    logic [7:0]          q100;
    logic [5:0]          q400;
    logic [11:0]         q4;
    logic [YEAR_W-1:0]   r100_full;
    logic [YEAR_W-1:0]   r400_full;
    logic [MOD100_W-1:0] r100;
    logic [MOD400_W-1:0] r400;
    logic                leap;
    logic                year_ok;
    logic                month_ok;
    logic                day_ok;
    logic                early;
    logic [YEAR_W-1:0]   ya;
    logic [11:0]         aq4;
    logic [7:0]          aq100;
    logic [5:0]          aq400;
    logic [DN_W-1:0]     dsum;
    logic [STATUS_W-1:0] chk;

    always_comb
    begin
        prod100   = 27'(in_year) * 27'(DIV100_MUL);
        q100      = prod100[26:DIV100_SHIFT];
        q400      = q100[7:2];
        q4        = in_year[YEAR_W-1:2];
        r100_full = in_year - YEAR_W'(16'(q100) * 16'd100);
        r400_full = in_year - YEAR_W'(16'(q400) * 16'd400);
        r100      = r100_full[MOD100_W-1:0];
        r400      = r400_full[MOD400_W-1:0];
        leap      = is_leap(r100, r400);

        year_ok  = (in_year != '0) && (in_year <= YEAR_W'(YEAR_MAX));
        month_ok = (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC);
        day_ok   = (in_day != '0) && (in_day <= days_in(in_month, leap));

        if (!year_ok) begin
            chk = ST_BAD_YEAR;
        end else if (!month_ok) begin
            chk = ST_BAD_MONTH;
        end else if (!day_ok) begin
            chk = ST_BAD_DAY;
        end else begin
            chk = ST_OK;
        end

        // Jan/Feb count as months 13/14 of the previous year
        early = (in_month < MONTH_MAR);
        ya    = in_year - YEAR_W'(early);
        aq4   = q4 - 12'(early && (in_year[1:0] == 2'd0));
        aq100 = q100 - 8'(early && (r100 == '0));
        aq400 = q400 - 6'(early && (r400 == '0));

        dsum = DN_W'(ya) * DN_W'(DAYS_PER_YEAR)
             + DN_W'(aq4) - DN_W'(aq100) + DN_W'(aq400)
             + DN_W'(month_offset(in_month)) + DN_W'(in_day) - DN_W'(DN_BIAS);

        item.req    = req_type;
        item.chk    = chk;
        item.month  = in_month;
        item.day    = in_day;
        item.year   = in_year;
        item.mod100 = r100;
        item.mod400 = r400;
        item.dnum   = dsum[DIFF_W-1:0];
    end

endmodule

// File: hw/rtl/cdc_queue.sv
// Two-entry queue between the front end and the date keeper.
`timescale 1ns / 1ps

module cdc_queue
    import cdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cdc_item_t     push_item,
    input  logic          pop,
    output cdc_item_t     head_item,
    output cdc_q_status_t qstat
);

    cdc_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item        = entry_reg[rd_ptr_reg];
    assign qstat.full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.head_valid = (count_reg != '0);

endmodule

// File: hw/rtl/cdc_back.sv
// Back end: holds the date, carries out each request and registers the result beat.
`timescale 1ns / 1ps

module cdc_back
    import cdc_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  cdc_item_t           head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [MONTH_W-1:0]  out_month,
    output logic [DAY_W-1:0]    out_day,
    output logic [YEAR_W-1:0]   out_year,
    output logic [DIFF_W-1:0]   day_difference
);

    logic [MONTH_W-1:0]  month_reg,  month_next;
    logic [DAY_W-1:0]    day_reg,    day_next;
    logic [YEAR_W-1:0]   year_reg,   year_next;
    logic [MOD100_W-1:0] mod100_reg, mod100_next;
    logic [MOD400_W-1:0] mod400_reg, mod400_next;
    logic [DIFF_W-1:0]   dnum_reg,   dnum_next;
    logic                loaded_reg, loaded_next;

    logic                ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ostatus_reg, ostatus_next;
    logic [DIFF_W-1:0]   odiff_reg,  odiff_next;
    logic [MONTH_W-1:0]  omonth_reg;
    logic [DAY_W-1:0]    oday_reg;
    logic [YEAR_W-1:0]   oyear_reg;

    logic                leap;
    logic [DAY_W-1:0]    dim;
    logic [DAY_W-1:0]    dim_prev;

    assign pop = head_valid && (!ovalid_reg || !out_stall);

    always_comb
    begin
        month_next   = month_reg;
        day_next     = day_reg;
        year_next    = year_reg;
        mod100_next  = mod100_reg;
        mod400_next  = mod400_reg;
        dnum_next    = dnum_reg;
        loaded_next  = loaded_reg;
        ostatus_next = ST_OK;
        odiff_next   = '0;

        leap     = is_leap(mod100_reg, mod400_reg);
        dim      = days_in(month_reg, leap);
        dim_prev = days_in(month_reg - 1'b1, leap);

        if (head_item.req == REQ_LOAD) begin
            ostatus_next = head_item.chk;
            if (head_item.chk == ST_OK) begin
                month_next  = head_item.month;
                day_next    = head_item.day;
                year_next   = head_item.year;
                mod100_next = head_item.mod100;
                mod400_next = head_item.mod400;
                dnum_next   = head_item.dnum;
                loaded_next = 1'b1;
            end
        end else if (!loaded_reg) begin
            ostatus_next = ST_NO_DATE;
        end else begin
            case (head_item.req)
                REQ_INC:
                begin
                    if (day_reg < dim) begin
                        day_next  = day_reg + 1'b1;
                        dnum_next = dnum_reg + 1'b1;
                    end else if (month_reg < MONTH_DEC) begin
                        month_next = month_reg + 1'b1;
                        day_next   = DAY_FIRST;
                        dnum_next  = dnum_reg + 1'b1;
                    end else if (year_reg < YEAR_W'(YEAR_MAX)) begin
                        year_next   = year_reg + 1'b1;
                        month_next  = MONTH_JAN;
                        day_next    = DAY_FIRST;
                        dnum_next   = dnum_reg + 1'b1;
                        mod100_next = (mod100_reg == MOD100_LAST) ? '0 : mod100_reg + 1'b1;
                        mod400_next = (mod400_reg == MOD400_LAST) ? '0 : mod400_reg + 1'b1;
                    end else begin
                        ostatus_next = ST_RANGE;
                    end
                end
                REQ_DEC:
                begin
                    if (day_reg > DAY_FIRST) begin
                        day_next  = day_reg - 1'b1;
                        dnum_next = dnum_reg - 1'b1;
                    end else if (month_reg > MONTH_JAN) begin
                        month_next = month_reg - 1'b1;
                        day_next   = dim_prev;
                        dnum_next  = dnum_reg - 1'b1;
                    end else if (year_reg > YEAR_W'(1)) begin
                        year_next   = year_reg - 1'b1;
                        month_next  = MONTH_DEC;
                        day_next    = DAY_LAST_DEC;
                        dnum_next   = dnum_reg - 1'b1;
                        mod100_next = (mod100_reg == '0) ? MOD100_LAST : mod100_reg - 1'b1;
                        mod400_next = (mod400_reg == '0) ? MOD400_LAST : mod400_reg - 1'b1;
                    end else begin
                        ostatus_next = ST_RANGE;
                    end
                end
                REQ_DIFF:
                begin
                    ostatus_next = head_item.chk;
                    if (head_item.chk == ST_OK) begin
                        odiff_next = (dnum_reg >= head_item.dnum) ?
                                     dnum_reg - head_item.dnum : head_item.dnum - dnum_reg;
                    end
                end
                default:
                begin
                    ostatus_next = ST_OK;
                end
            endcase
        end

        ovalid_next = pop || (ovalid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            month_reg  <= '0;
            day_reg    <= '0;
            year_reg   <= '0;
            mod100_reg <= '0;
            mod400_reg <= '0;
            dnum_reg   <= '0;
            loaded_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
            if (pop) begin
                month_reg  <= month_next;
                day_reg    <= day_next;
                year_reg   <= year_next;
                mod100_reg <= mod100_next;
                mod400_reg <= mod400_next;
                dnum_reg   <= dnum_next;
                loaded_reg <= loaded_next;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (pop) begin
            ostatus_reg <= ostatus_next;
            odiff_reg   <= odiff_next;
            omonth_reg  <= month_next;
            oday_reg    <= day_next;
            oyear_reg   <= year_next;
        end
    end

    assign out_valid      = ovalid_reg;
    assign status         = ostatus_reg;
    assign out_month      = omonth_reg;
    assign out_day        = oday_reg;
    assign out_year       = oyear_reg;
    assign day_difference = odiff_reg;

endmodule

// File: hw/rtl/calendar_date_counter.sv
// An accepted request beat is retired by the back end into its registered result beat.
// Throughput: one request per cycle unless in_stall; the keeper retires one queued request
// per cycle unless out_stall; the queue takes up to two beats while a result waits.
// Reset (rst_n, async, active low): no date loaded, stored date all zero, queue and
// result register empty. No clearing pass is needed.
`timescale 1ns / 1ps

module calendar_date_counter
    import cdc_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic                clk,
    input  logic                rst_n,

    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [MONTH_W-1:0]  in_month,
    input  logic [DAY_W-1:0]    in_day,
    input  logic [YEAR_W-1:0]   in_year,

    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [MONTH_W-1:0]  out_month,
    output logic [DAY_W-1:0]    out_day,
    output logic [YEAR_W-1:0]   out_year,
    output logic [DIFF_W-1:0]   day_difference
);

    // Front end: validates the given date and precomputes its day number and
    // year-mod-100/400 residues, so the back end never divides.
    cdc_item_t     front_item;
    cdc_item_t     head_item;
    cdc_q_status_t qstat;
    logic          push;
    logic          pop;

    cdc_front #(
        .YEAR_MAX (YEAR_MAX)
    ) u_front (
        .req_type (req_type),
        .in_month (in_month),
        .in_day   (in_day),
        .in_year  (in_year),
        .item     (front_item)
    );

    // input beat is taken whenever the queue has room
    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    cdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // Back end: keeps the date plus its running day number; a difference is
    // just one compare and subtract against the precomputed number of the given date.
    cdc_back #(
        .YEAR_MAX (YEAR_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (qstat.head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_month      (out_month),
        .out_day        (out_day),
        .out_year       (out_year),
        .day_difference (day_difference)
    );

`ifndef SYNTHESIS
    // a nonzero difference only comes with a good status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (day_difference != '0)) |-> (status == ST_OK))
        else $error("day difference reported with error status");

    // a successful step, load or difference always leaves a real date behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_OK)) |->
        ((out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) && (out_day != '0)
         && (out_year != '0)))
        else $error("ok result carries an invalid date");

    // a popped request always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("request retired without a result beat");
`endif

endmodule
